@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// invariant at every edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

@@ hdl/lsh_pkg.sv @@
// ---------------------------------------------------------------------------
// lsh_pkg
// types and constants of the 3x3 laplacian sharpen filter
// ---------------------------------------------------------------------------
package lsh_pkg;

	localparam int SAMPLE_W    = 8;
	localparam int WIDTH_W     = 11;
	localparam int HEIGHT_W    = 16;
	localparam int CHAN_CFG_W  = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd3;

	// register reset values
	localparam logic                  RST_CENTER   = 1'b0;
	localparam logic [WIDTH_W-1:0]    RST_WIDTH    = 11'd1024;
	localparam logic [HEIGHT_W-1:0]   RST_HEIGHT   = 16'd1024;
	localparam logic [CHAN_CFG_W-1:0] RST_CHANNELS = 3'd1;

	// word modes
	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_DRAIN  = 1'b1;

	// kernel constants
	localparam int CENTER_SHARPEN = 5;
	localparam int CENTER_EDGE    = 4;
	localparam int PIX_MAX        = 255;
	localparam int PIX_MIN        = 0;

	typedef struct packed {
		logic                mode;
		logic [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] filtered;
		logic                frame_last;
	} out_item_t;

	// neighborhood of one sample
	typedef struct packed {
		logic [SAMPLE_W-1:0] ctr;
		logic [SAMPLE_W-1:0] up;
		logic [SAMPLE_W-1:0] below;
		logic [SAMPLE_W-1:0] left;
		logic [SAMPLE_W-1:0] right;
	} tap_t;

endpackage

@@ hdl/laplacian_sharpen_3x3_core.sv @@
// ---------------------------------------------------------------------------
// laplacian_sharpen_3x3_core
// 3x3 laplacian sharpen / edge filter over an interleaved raster stream
// ---------------------------------------------------------------------------
// sample channel: one word per accepted edge (sample_valid high, sample_stall
//   low), either an image sample in raster order or a drain tick
// filt channel: filtered words in raster order, frame_last on the final one
// cfg port: single-cycle writes of center_select, width, height, channels;
//   a geometry write restarts the frame
// the result for row r comes out while row r+1 streams in; after the last
//   row, one drain tick per sample of that row pushes it out
// the word that causes a result is registered in stage one, the result in the output register
// throughput: one word per cycle while sample_stall stays low, set by the
//   two-read one-write line ram that holds the row above and the current row side by side
// reset: positions clear and registers take their defaults; the line ram is
//   not cleared, row 0 fills it before any read
// a stalled result holds in the output register while one more word is
//   taken; sample_stall rises once that word is also waiting
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module laplacian_sharpen_3x3_core #(
	parameter int MAX_WIDTH    = 1024,
	parameter int MAX_CHANNELS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  lsh_pkg::in_item_t             sample_word,
	output logic                          filt_valid,
	input  logic                          filt_stall,
	output lsh_pkg::out_item_t            filt_word,
	input  logic                          cfg_wen,
	input  logic [lsh_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [lsh_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	import lsh_pkg::*;

	localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int POS_W  = $clog2(DEPTH + 1);
	localparam int CH_W   = $clog2(MAX_CHANNELS + 1);

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_STORE = 2'd1;
	localparam logic [1:0] KIND_CALC  = 2'd2;
	localparam logic [1:0] KIND_DRAIN = 2'd3;

	typedef struct packed {
		logic [SAMPLE_W-1:0] above;
		logic [SAMPLE_W-1:0] current;
	} line_word_t;

	// configuration
	logic                  center_q;
	logic [WIDTH_W-1:0]    width_q;
	logic [HEIGHT_W-1:0]   height_q;
	logic [CHAN_CFG_W-1:0] chan_q;
	logic                  cfg_restart;

	logic [CH_W-1:0]     eff_ch;
	logic [WIDTH_W-1:0]  eff_w;
	logic [POS_W-1:0]    eff_len;
	logic [HEIGHT_W-1:0] eff_h;

	// positions
	logic [POS_W-1:0]    in_col_q;
	logic [HEIGHT_W-1:0] in_row_q;
	logic [POS_W-1:0]    out_col_q;
	logic [HEIGHT_W-1:0] out_row_q;

	logic [POS_W-1:0]    in_col_inc;
	logic [HEIGHT_W-1:0] in_row_inc;
	logic                in_wrap;
	logic [POS_W-1:0]    out_col_inc;
	logic [HEIGHT_W-1:0] out_row_inc;
	logic                out_wrap;

	// entry decode
	logic              sample_fire;
	logic [1:0]        kind;
	logic              last;
	logic [POS_W-1:0]  pos;
	logic [POS_W:0]    pos_rt;
	logic              lf_ok;
	logic              rt_ok;
	logic [ADDR_W-1:0] rd_addr_a;
	logic [ADDR_W-1:0] rd_addr_b;
	logic              load_s1;

	// stage one
	logic                valid_s1;
	logic [1:0]          kind_s1;
	logic                last_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [SAMPLE_W-1:0] smp_s1;
	logic                lf_ok_s1;
	logic                rt_ok_s1;
	logic                fwd_a_s1;
	line_word_t          fwd_a_data_s1;
	logic                fwd_b_s1;
	logic [SAMPLE_W-1:0] fwd_b_data_s1;

	logic [$bits(line_word_t)-1:0] ram_a;
	logic [$bits(line_word_t)-1:0] ram_b;
	line_word_t          word_a;
	line_word_t          word_b;
	logic [SAMPLE_W-1:0] ctr;
	logic [SAMPLE_W-1:0] lf_hist;
	tap_t                taps;
	logic [SAMPLE_W-1:0] kern_out;
	logic                produce_s1;
	logic                s1_go;
	logic                out_free;
	logic                wr_en;
	line_word_t          wr_word;

	logic [SAMPLE_W-1:0] hist_q [MAX_CHANNELS];

	// output register
	logic      out_valid_q;
	out_item_t out_word_q;

	// -------------------------------------------------------------------
	// configuration
	// -------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= RST_CENTER;
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			chan_q   <= RST_CHANNELS;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_CENTER:   center_q <= cfg_wdata[0];
				REG_WIDTH:    width_q  <= cfg_wdata[WIDTH_W-1:0];
				REG_HEIGHT:   height_q <= cfg_wdata[HEIGHT_W-1:0];
				REG_CHANNELS: chan_q   <= cfg_wdata[CHAN_CFG_W-1:0];
			endcase
		end
	end

	assign cfg_restart = cfg_wen && (cfg_idx != REG_CENTER);

	// zero and out-of-range settings fold to the nearest legal value
	always_comb begin
		if (chan_q == '0) begin
			eff_ch = CH_W'(1);
		end else if (32'(chan_q) > MAX_CHANNELS) begin
			eff_ch = CH_W'(MAX_CHANNELS);
		end else begin
			eff_ch = CH_W'(chan_q);
		end
		if (width_q == '0) begin
			eff_w = WIDTH_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = WIDTH_W'(MAX_WIDTH);
		end else begin
			eff_w = width_q;
		end
		eff_len = POS_W'(eff_w) * POS_W'(eff_ch);
		eff_h   = (height_q == '0) ? HEIGHT_W'(1) : height_q;
	end

	// -------------------------------------------------------------------
	// entry: classify the word and issue the line ram reads
	// -------------------------------------------------------------------
	assign sample_fire = sample_valid && !sample_stall;

	always_comb begin
		in_col_inc  = POS_W'(in_col_q + 1'b1);
		in_wrap     = (in_col_inc >= eff_len);
		in_row_inc  = in_row_q + 1'b1;
		out_col_inc = POS_W'(out_col_q + 1'b1);
		out_wrap    = (out_col_inc >= eff_len);
		out_row_inc = out_row_q + 1'b1;

		kind = KIND_NONE;
		last = 1'b0;
		pos  = in_col_q;
		if (sample_word.mode == MODE_SAMPLE) begin
			if (in_row_q < eff_h && in_col_q < eff_len) begin
				kind = (in_row_q == '0) ? KIND_STORE : KIND_CALC;
			end
		end else begin
			pos = out_col_q;
			if (in_row_q >= eff_h && out_row_q < eff_h && out_col_q < eff_len) begin
				kind = KIND_DRAIN;
				last = out_wrap && (out_row_inc >= eff_h);
			end
		end

		pos_rt    = {1'b0, pos} + (POS_W+1)'(eff_ch);
		rt_ok     = pos_rt < {1'b0, eff_len};
		lf_ok     = pos >= POS_W'(eff_ch);
		rd_addr_a = pos[ADDR_W-1:0];
		rd_addr_b = pos_rt[ADDR_W-1:0];
	end

	assign load_s1 = sample_fire && (kind != KIND_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (sample_fire) begin
			unique case (kind)
				KIND_STORE: begin
					in_col_q <= in_wrap ? '0 : in_col_inc;
					if (in_wrap) begin
						in_row_q <= in_row_inc;
					end
				end
				KIND_CALC: begin
					in_col_q  <= in_wrap ? '0 : in_col_inc;
					out_col_q <= out_wrap ? '0 : out_col_inc;
					if (in_wrap) begin
						in_row_q <= in_row_inc;
					end
					if (out_wrap) begin
						out_row_q <= out_row_inc;
					end
				end
				KIND_DRAIN: begin
					if (last) begin
						in_col_q  <= '0;
						in_row_q  <= '0;
						out_col_q <= '0;
						out_row_q <= '0;
					end else begin
						out_col_q <= out_wrap ? '0 : out_col_inc;
						if (out_wrap) begin
							out_row_q <= out_row_inc;
						end
					end
				end
				KIND_NONE: begin
				end
			endcase
		end
	end

	// -------------------------------------------------------------------
	// stage one: ram data, neighborhood, write back
	// -------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	// a write leaving stage one in the same cycle is forwarded past the ram
	always_ff @(posedge clk) begin
		if (load_s1) begin
			kind_s1       <= kind;
			last_s1       <= last;
			addr_s1       <= rd_addr_a;
			smp_s1        <= sample_word.sample;
			lf_ok_s1      <= lf_ok;
			rt_ok_s1      <= rt_ok;
			fwd_a_s1      <= wr_en && (addr_s1 == rd_addr_a);
			fwd_a_data_s1 <= wr_word;
			fwd_b_s1      <= wr_en && (addr_s1 == rd_addr_b);
			fwd_b_data_s1 <= wr_word.current;
		end
	end

	lsh_ram #(
		.WIDTH($bits(line_word_t)),
		.DEPTH(DEPTH)
	) u_line_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (addr_s1),
		.wr_data   (wr_word),
		.rd_en     (load_s1),
		.rd_addr_a (rd_addr_a),
		.rd_data_a (ram_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_b (ram_b)
	);

	// left neighbor is the center of the compute ch samples back
	always_comb begin
		lf_hist = hist_q[0];
		for (int i = 1; i < MAX_CHANNELS; i++) begin
			if (CH_W'(i + 1) == eff_ch) begin
				lf_hist = hist_q[i];
			end
		end
	end

	always_comb begin
		word_a      = fwd_a_s1 ? fwd_a_data_s1 : line_word_t'(ram_a);
		word_b      = line_word_t'(ram_b);
		ctr         = word_a.current;
		taps.ctr    = ctr;
		taps.up     = word_a.above;
		taps.below  = (kind_s1 == KIND_CALC) ? smp_s1 : ctr;
		taps.left   = lf_ok_s1 ? lf_hist : ctr;
		taps.right  = !rt_ok_s1 ? ctr : (fwd_b_s1 ? fwd_b_data_s1 : word_b.current);

		produce_s1 = (kind_s1 == KIND_CALC) || (kind_s1 == KIND_DRAIN);
		out_free   = !out_valid_q || !filt_stall;
		s1_go      = valid_s1 && (!produce_s1 || out_free);
		wr_en      = s1_go;

		unique case (kind_s1)
			KIND_STORE: begin
				wr_word.above   = smp_s1;
				wr_word.current = smp_s1;
			end
			KIND_CALC: begin
				wr_word.above   = ctr;
				wr_word.current = smp_s1;
			end
			default: begin
				wr_word.above   = ctr;
				wr_word.current = ctr;
			end
		endcase
	end

	assign sample_stall = valid_s1 && !s1_go;

	always_ff @(posedge clk) begin
		if (s1_go && produce_s1) begin
			hist_q[0] <= ctr;
			for (int i = 1; i < MAX_CHANNELS; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	lsh_kernel u_kernel (
		.center_select (center_q),
		.taps          (taps),
		.filtered      (kern_out)
	);

	// -------------------------------------------------------------------
	// output register
	// -------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && produce_s1) begin
			out_valid_q <= 1'b1;
		end else if (!filt_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && produce_s1) begin
			out_word_q.filtered   <= kern_out;
			out_word_q.frame_last <= last_s1;
		end
	end

	assign filt_valid = out_valid_q;
	assign filt_word  = out_word_q;

	// -------------------------------------------------------------------
	// assertions
	// -------------------------------------------------------------------
	`ASSERT_IMPLIES(a_s1_hold, valid_s1 && !s1_go, out_valid_q && filt_stall, "stage one held without a stalled result")
	`ASSERT_IMPLIES(a_col_track, sample_fire && kind == KIND_CALC, in_col_q == out_col_q, "input and output columns out of step")
	`ASSERT_NEXT(a_frame_restart, sample_fire && kind == KIND_DRAIN && last, in_row_q == '0 && out_row_q == '0 && in_col_q == '0 && out_col_q == '0, "positions not cleared after frame end")
	`ASSERT_ALWAYS(a_out_row_range, out_row_q < eff_h, "output row past image height")

endmodule

@@ hdl/lsh_ram.sv @@
// ---------------------------------------------------------------------------
// lsh_ram
// generic ram, one write port and two registered read ports
// ---------------------------------------------------------------------------
module lsh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr_a,
	output logic [WIDTH-1:0]  rd_data_a,
	input  logic [ADDR_W-1:0] rd_addr_b,
	output logic [WIDTH-1:0]  rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the contents before a same-cycle write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

@@ hdl/lsh_kernel.sv @@
// ---------------------------------------------------------------------------
// lsh_kernel
// weighted center minus four neighbors, clamped to the sample range
// ---------------------------------------------------------------------------
module lsh_kernel (
	input  logic                      center_select,
	input  lsh_pkg::tap_t             taps,
	output logic [lsh_pkg::SAMPLE_W-1:0] filtered
);

	import lsh_pkg::*;

	localparam int ACC_W = 11;

	logic [ACC_W-1:0]        weight;
	logic [ACC_W-1:0]        kc;
	logic [ACC_W-1:0]        nsum;
	logic signed [ACC_W:0]   diff;

	always_comb begin
		weight = center_select ? ACC_W'(CENTER_EDGE) : ACC_W'(CENTER_SHARPEN);
		kc     = ACC_W'(taps.ctr) * weight;
		nsum   = ACC_W'(taps.up) + ACC_W'(taps.below) + ACC_W'(taps.left)
			+ ACC_W'(taps.right);
		diff   = $signed({1'b0, kc}) - $signed({1'b0, nsum});
		if (diff[ACC_W]) begin
			filtered = SAMPLE_W'(PIX_MIN);
		end else if (diff[ACC_W-1:0] > ACC_W'(PIX_MAX)) begin
			filtered = SAMPLE_W'(PIX_MAX);
		end else begin
			filtered = diff[SAMPLE_W-1:0];
		end
	end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the 3x3 laplacian sharpen / edge filter core:
// drives raster frames with drain ticks and noise words, predicts every
// filtered word from its own copy of the line stores, and checks results
// in order under idle, stall and long hold-off patterns
// ---------------------------------------------------------------------------
module tb;
	import lsh_pkg::*;

	localparam int MAX_W       = 1024;
	localparam int MAX_CH      = 4;
	localparam int STORE_DEPTH = MAX_W * MAX_CH;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_WORDS  = 500;

	// predicts filtered words and holds those not yet seen
	class sharpen_scoreboard;
		bit [7:0] above [STORE_DEPTH];
		bit [7:0] current [STORE_DEPTH];
		int unsigned in_col, in_row, out_col, out_row;
		bit edge_mode;
		bit [WIDTH_W-1:0] width_reg;
		bit [HEIGHT_W-1:0] height_reg;
		bit [CHAN_CFG_W-1:0] chan_reg;
		out_item_t pending_pixels[$];
		int unsigned mismatches;
		int unsigned checked;

		function new();
			edge_mode = RST_CENTER;
			width_reg = RST_WIDTH;
			height_reg = RST_HEIGHT;
			chan_reg = RST_CHANNELS;
			mismatches = 0;
			checked = 0;
			restart();
		endfunction

		function void restart();
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
		endfunction

		function int unsigned chans();
			if (chan_reg == 0)
				return 1;
			return (chan_reg > MAX_CH) ? MAX_CH : chan_reg;
		endfunction

		function int unsigned line_len();
			int unsigned w;
			w = (width_reg == 0) ? 1 : width_reg;
			if (w > MAX_W)
				w = MAX_W;
			return w * chans();
		endfunction

		function int unsigned rows();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_CENTER: begin
					edge_mode = data[0];
				end
				REG_WIDTH: begin
					width_reg = data[WIDTH_W-1:0];
					restart();
				end
				REG_HEIGHT: begin
					height_reg = data[HEIGHT_W-1:0];
					restart();
				end
				REG_CHANNELS: begin
					chan_reg = data[CHAN_CFG_W-1:0];
					restart();
				end
				default: begin
				end
			endcase
		endfunction

		// laplacian at position p; the centre rotates into the row above
		function logic [7:0] kernel(int unsigned p, int unsigned ch, int unsigned len,
				logic [7:0] below);
			int up, mid, lf, rt, bl, s;
			up = above[p];
			mid = current[p];
			bl = below;
			lf = (p >= ch) ? int'(above[p - ch]) : mid;
			rt = (p + ch < len) ? int'(current[p + ch]) : mid;
			s = (edge_mode ? CENTER_EDGE : CENTER_SHARPEN) * mid - up - bl - lf - rt;
			above[p] = mid[7:0];
			if (s > PIX_MAX)
				s = PIX_MAX;
			if (s < PIX_MIN)
				s = PIX_MIN;
			return s[7:0];
		endfunction

		function void advance_out(int unsigned len);
			out_col++;
			if (out_col >= len) begin
				out_col = 0;
				out_row++;
			end
		endfunction

		// returns 1 when the word moved the filter along, 0 when it was ignored
		function bit take_word(in_item_t w);
			int unsigned ch, len, h, p;
			out_item_t px;
			ch = chans();
			len = line_len();
			h = rows();
			if (w.mode == MODE_SAMPLE) begin
				p = in_col;
				if (in_row >= h || p >= len)
					return 0;
				if (in_row == 0) begin
					above[p] = w.sample;
				end else begin
					px.filtered = kernel(p, ch, len, w.sample);
					px.frame_last = 1'b0;
					pending_pixels.push_back(px);
					advance_out(len);
				end
				current[p] = w.sample;
				in_col++;
				if (in_col >= len) begin
					in_col = 0;
					in_row++;
				end
				return 1;
			end
			if (in_row < h || out_row >= h || out_col >= len)
				return 0;
			p = out_col;
			px.filtered = kernel(p, ch, len, current[p]);
			px.frame_last = 1'b0;
			advance_out(len);
			if (out_row >= h) begin
				px.frame_last = 1'b1;
				restart();
			end
			pending_pixels.push_back(px);
			return 1;
		endfunction

		task report_mismatch(string what, int unsigned got, int unsigned want);
			mismatches++;
			$display("[%0t] word %0d %s: got %0d, expected %0d", $time, checked, what,
				got, want);
		endtask

		task check_pixel(out_item_t got);
			out_item_t want;
			checked++;
			if (pending_pixels.size() == 0) begin
				report_mismatch("arrived with none expected, filtered", got.filtered, 0);
			end else begin
				want = pending_pixels.pop_front();
				if (got.filtered !== want.filtered)
					report_mismatch("filtered", got.filtered, want.filtered);
				if (got.frame_last !== want.frame_last)
					report_mismatch("frame_last", got.frame_last, want.frame_last);
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	in_item_t sample_word = '0;
	logic filt_valid;
	logic filt_stall = 1'b0;
	out_item_t filt_word;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	sharpen_scoreboard book;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_req = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned used_words = 0;

	laplacian_sharpen_3x3_core #(
		.MAX_WIDTH(MAX_W),
		.MAX_CHANNELS(MAX_CH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_word(sample_word),
		.filt_valid(filt_valid),
		.filt_stall(filt_stall),
		.filt_word(filt_word),
		.cfg_wen(cfg_wen),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stall, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			filt_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			filt_stall <= 1'b1;
		end else begin
			filt_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && filt_valid && !filt_stall)
			book.check_pixel(filt_word);
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (filt_valid && !filt_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[%0t] no word moved for %0d cycles", $time, QUIET_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic int unsigned idle_run(int unsigned pct);
		int unsigned n;
		n = 0;
		while ($urandom_range(99) < pct)
			n++;
		return n;
	endfunction

	function automatic logic [7:0] pick_sample();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// called and returns at a falling edge
	task automatic send_word(input logic mode, input logic [7:0] smp);
		int unsigned gap;
		in_item_t w;
		w.mode = mode;
		w.sample = smp;
		gap = idle_run(send_idle_pct);
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample_word <= w;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		if (book.take_word(w))
			used_words++;
		@(negedge clk);
	endtask

	// let every expected word out, then give in-flight ignored words time to retire
	task automatic settle();
		sample_valid <= 1'b0;
		while (book.pending_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		book.write_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic set_center(input bit center);
		write_reg(REG_CENTER, {15'($urandom), center});
		cfg_wen <= 1'b0;
	endtask

	// upper data bits are don't-care and get random values
	task automatic set_regs(input bit center, input int unsigned w_val,
			input int unsigned h_val, input int unsigned c_val);
		write_reg(REG_CENTER, {15'($urandom), center});
		write_reg(REG_WIDTH, {5'($urandom), 11'(w_val)});
		write_reg(REG_HEIGHT, 16'(h_val));
		write_reg(REG_CHANNELS, {13'($urandom), 3'(c_val)});
		cfg_wen <= 1'b0;
	endtask

	// one frame with noise words; a frame cut short gets no drain
	task automatic run_frame(input bit center, input int unsigned w_val,
			input int unsigned h_val, input int unsigned c_val,
			input int unsigned rows_sent, input bit hold);
		int unsigned len;
		settle();
		set_regs(center, w_val, h_val, c_val);
		len = book.line_len();
		if (hold)
			hold_req <= hold_req + 1;
		for (int unsigned r = 0; r < rows_sent; r++) begin
			for (int unsigned p = 0; p < len; p++) begin
				// drain before the last row is in: ignored
				if ($urandom_range(39) == 0)
					send_word(MODE_DRAIN, 8'($urandom));
				send_word(MODE_SAMPLE, pick_sample());
			end
			if ($urandom_range(9) == 0) begin
				settle();
				set_center($urandom_range(1));
			end
		end
		if (rows_sent >= book.rows()) begin
			// samples past the end of the frame: ignored
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 3)) send_word(MODE_SAMPLE, pick_sample());
			repeat (len) send_word(MODE_DRAIN, 8'($urandom));
			// nothing pending: ignored
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 3)) send_word(MODE_DRAIN, 8'($urandom));
		end
	endtask

	initial begin
		int unsigned frame_no, w_val, h_val, c_val, eff_h, rows_sent;
		book = new();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// small frame: clamps at both ends, early drain, late sample, spare drain
		settle();
		set_regs(1'b0, 3, 2, 1);
		send_word(MODE_SAMPLE, 8'd0);
		send_word(MODE_SAMPLE, 8'd255);
		send_word(MODE_SAMPLE, 8'd0);
		send_word(MODE_DRAIN, 8'd0);
		send_word(MODE_SAMPLE, 8'd255);
		send_word(MODE_SAMPLE, 8'd0);
		send_word(MODE_SAMPLE, 8'd255);
		send_word(MODE_SAMPLE, 8'd77);
		repeat (3) send_word(MODE_DRAIN, 8'hff);
		send_word(MODE_DRAIN, 8'h00);

		// zero geometry reads as one pixel, one row, one channel
		settle();
		set_regs(1'b1, 0, 0, 0);
		send_word(MODE_SAMPLE, 8'd200);
		send_word(MODE_DRAIN, 8'd0);
		settle();
		set_center(1'b0);
		send_word(MODE_SAMPLE, 8'd200);
		send_word(MODE_DRAIN, 8'd0);

		// channel count above the maximum
		settle();
		set_regs(1'b0, 1, 2, 7);
		repeat (8) send_word(MODE_SAMPLE, pick_sample());
		repeat (4) send_word(MODE_DRAIN, 8'($urandom));

		used_words = 0;
		frame_no = 0;
		while (used_words < RANDOM_WORDS) begin
			case (frame_no % 4)
				0: begin send_idle_pct = 0;  stall_pct <= 0;  end
				1: begin send_idle_pct = 74; stall_pct <= 0;  end
				2: begin send_idle_pct = 0;  stall_pct <= 74; end
				default: begin send_idle_pct = 7; stall_pct <= 7; end
			endcase
			if (frame_no == 4) begin
				// sender keeps offering while the receiver holds off
				run_frame($urandom_range(1), 8, 3, 4, 3, 1'b1);
			end else if (frame_no == 5) begin
				// tallest frame, cut short after a few rows
				run_frame($urandom_range(1), 4, 65535, 1, 3, 1'b0);
			end else begin
				w_val = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 10);
				h_val = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 5);
				c_val = $urandom_range(1, 4);
				if ($urandom_range(9) == 0)
					c_val = 0;
				else if ($urandom_range(9) == 0)
					c_val = $urandom_range(5, 7);
				eff_h = (h_val == 0) ? 1 : h_val;
				rows_sent = eff_h;
				if (eff_h > 1 && $urandom_range(9) == 0)
					rows_sent = $urandom_range(1, eff_h - 1);
				run_frame($urandom_range(1), w_val, h_val, c_val, rows_sent, 1'b0);
			end
			frame_no++;
		end

		// one row at full width and the start of the next, register value above the maximum
		send_idle_pct = 7;
		stall_pct <= 7;
		settle();
		set_regs($urandom_range(1), 2047, 2, 1);
		repeat (MAX_W + 2) send_word(MODE_SAMPLE, pick_sample());

		settle();
		if (book.mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ laplacian_sharpen_3x3_core.f @@
+incdir+hdl
hdl/lsh_pkg.sv
hdl/lsh_ram.sv
hdl/lsh_kernel.sv
hdl/laplacian_sharpen_3x3_core.sv
tb/sv/tb.sv
